>>> rtl/crcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 packet deframer package
// Shared constants, result record and the bytewise CRC-32 update.
// ----------------------------------------------------------------------------
package crcpd_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [9:0]  HDR_BYTES = 10'd12;
   localparam logic [9:0]  CNT_MAX = 10'd1023;
   localparam logic [9:0]  CRC_BYTES = 10'd4;
   localparam logic [1:0]  TYPE_NONE = 2'd0;
   localparam logic [1:0]  TYPE_DATA = 2'd1;

   localparam logic [2:0]  ST_OK          = 3'd0;
   localparam logic [2:0]  ST_NO_HEADER   = 3'd1;
   localparam logic [2:0]  ST_TOO_LONG    = 3'd2;
   localparam logic [2:0]  ST_BAD_TYPE    = 3'd3;
   localparam logic [2:0]  ST_BAD_LENGTH  = 3'd4;
   localparam logic [2:0]  ST_HEADER_CRC  = 3'd5;
   localparam logic [2:0]  ST_SHORT       = 3'd6;
   localparam logic [2:0]  ST_PAYLOAD_CRC = 3'd7;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;

   // Declared from the highest bits down so that payload_byte lands at bit 0.
   typedef struct packed {
      logic [31:0] timestamp;
      logic [15:0] payload_length;
      logic [7:0]  seq_number;
      logic [4:0]  window;
      logic        truncated;
      logic [1:0]  pkt_type;
      logic [2:0]  status;
      logic [7:0]  payload_byte;
   } rsp_fields_type;

   localparam int RSP_BITS = $bits(rsp_fields_type);
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/crc32_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 packet deframer
// Parses the datagram header, checks both CRC-32 fields, forwards payload
// bytes and gives one verdict beat at the end of every frame.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         tdata: data_byte; tlast: end_of_frame
//  rsp_     out        tuser: kind; tdata: payload_byte .. timestamp
//
// One byte is accepted per cycle unless the output stalls; each byte is captured
// in the input register, and any result of it moves on to the result register.
// The frame parser, including the bytewise CRC update, sits between them.
// Reset is synchronous and returns the parser to the start of a frame.
// When the result register is full and rsp_tready is low, a full input register
// holds and req_tready falls.
// ----------------------------------------------------------------------------
module crc32_packet_deframer #(
   parameter int MAX_PAYLOAD = 512,
   parameter int MAX_FRAME = 528
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [crcpd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [7:0] payload_byte, [10:8] status, [12:11] pkt_type, [13] truncated,
   // [18:14] window, [26:19] seq_number, [42:27] payload_length,
   // [74:43] timestamp, upper bits zero
   output logic rsp_tuser          // [0] kind
);
   import crcpd_pkg::*;

   localparam logic [16:0] MaxPayload = 17'(MAX_PAYLOAD);
   localparam logic [11:0] MaxFrame = 12'(MAX_FRAME);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic in_last_ff;
   logic advance;

   logic [9:0]  byte_count_ff, byte_count_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] timestamp_ff, timestamp_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic [31:0] run_crc_ff, run_crc_in;
   logic        header_good_ff, header_good_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   rsp_fields_type rsp_fields_ff;

   logic [1:0]  pkt_type;
   logic        fwd;
   logic        has_result;
   logic [17:0] pos;
   logic [17:0] payload_end;
   logic [17:0] crc_end;
   logic [10:0] frame_len;
   logic [2:0]  status;
   rsp_fields_type result;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_comb begin
      byte_count_in = byte_count_ff;
      first_byte_in = first_byte_ff;
      seq_in = seq_ff;
      length_in = length_ff;
      timestamp_in = timestamp_ff;
      rx_crc_in = rx_crc_ff;
      run_crc_in = run_crc_ff;
      header_good_in = header_good_ff;
      pkt_type = first_byte_ff[7:6];
      fwd = 1'b0;

      if (byte_count_ff < 10'd8) begin
         run_crc_in = crc32_byte(run_crc_ff, in_byte_ff);
      end
      if (byte_count_ff == 10'd0) begin
         first_byte_in = in_byte_ff;
         pkt_type = in_byte_ff[7:6];
      end else if (byte_count_ff == 10'd1) begin
         seq_in = in_byte_ff;
      end else if (byte_count_ff == 10'd2 || byte_count_ff == 10'd3) begin
         length_in = {length_ff[7:0], in_byte_ff};
      end else if (byte_count_ff < 10'd8) begin
         timestamp_in = {timestamp_ff[23:0], in_byte_ff};
      end else if (byte_count_ff < HDR_BYTES) begin
         rx_crc_in = {rx_crc_ff[23:0], in_byte_ff};
         if (byte_count_ff == HDR_BYTES - 10'd1) begin
            header_good_in = (pkt_type != TYPE_NONE) && ({1'b0, length_ff} <= MaxPayload)
               && ((run_crc_ff ^ CRC_INIT) == rx_crc_in);
            run_crc_in = CRC_INIT;
         end
      end else if (header_good_ff && pkt_type == TYPE_DATA) begin
         if (pos < payload_end) begin
            run_crc_in = crc32_byte(run_crc_ff, in_byte_ff);
            fwd = 1'b1;
         end else if (pos < crc_end) begin
            rx_crc_in = {rx_crc_ff[23:0], in_byte_ff};
         end
      end

      if (byte_count_ff < CNT_MAX) begin
         byte_count_in = byte_count_ff + 10'd1;
      end
   end

   assign pos = {8'd0, byte_count_ff};
   assign payload_end = {8'd0, HDR_BYTES} + {2'd0, length_ff};
   assign crc_end = payload_end + {8'd0, CRC_BYTES};
   assign frame_len = {1'b0, byte_count_ff} + 11'd1;

   always_comb begin
      if (frame_len < {1'b0, HDR_BYTES}) begin
         status = ST_NO_HEADER;
      end else if ({1'b0, frame_len} > MaxFrame) begin
         status = ST_TOO_LONG;
      end else if (pkt_type == TYPE_NONE) begin
         status = ST_BAD_TYPE;
      end else if ({1'b0, length_in} > MaxPayload) begin
         status = ST_BAD_LENGTH;
      end else if (!header_good_in) begin
         status = ST_HEADER_CRC;
      end else if (pkt_type == TYPE_DATA
                   && {7'd0, frame_len} < ({8'd0, HDR_BYTES} + {2'd0, length_in}
                                           + {8'd0, CRC_BYTES})) begin
         status = ST_SHORT;
      end else if (pkt_type == TYPE_DATA && (run_crc_in ^ CRC_INIT) != rx_crc_in) begin
         status = ST_PAYLOAD_CRC;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result = '0;
      if (in_last_ff) begin
         result.status = status;
         if (status != ST_NO_HEADER) begin
            result.pkt_type = pkt_type;
            result.truncated = first_byte_in[5];
            result.window = first_byte_in[4:0];
            result.seq_number = seq_in;
            result.payload_length = length_in;
            result.timestamp = timestamp_in;
         end
      end else begin
         result.payload_byte = in_byte_ff;
      end
   end

   assign has_result = in_last_ff || fwd;

   always_comb begin
      if (advance) begin
         rsp_valid_in = has_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && has_result) begin
         rsp_kind_ff <= in_last_ff ? KIND_VERDICT : KIND_PAYLOAD;
         rsp_fields_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         byte_count_ff <= '0;
         first_byte_ff <= '0;
         seq_ff <= '0;
         length_ff <= '0;
         timestamp_ff <= '0;
         rx_crc_ff <= '0;
         run_crc_ff <= CRC_INIT;
         header_good_ff <= 1'b0;
      end else if (advance) begin
         byte_count_ff <= byte_count_in;
         first_byte_ff <= first_byte_in;
         seq_ff <= seq_in;
         length_ff <= length_in;
         timestamp_ff <= timestamp_in;
         rx_crc_ff <= rx_crc_in;
         run_crc_ff <= run_crc_in;
         header_good_ff <= header_good_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_BITS){1'b0}}, rsp_fields_ff};

endmodule

>>> sim/tb_crc32_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-32 packet deframer
// Sends whole datagrams one byte per beat, some clean and some broken. It
// predicts every forwarded payload byte and every end-of-frame verdict, and it
// compares each result beat field by field in arrival order. Both sides of the
// block go idle at random, and the result side also holds off for a long
// stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_crc32_packet_deframer;
   import crcpd_pkg::*;

   typedef struct {
      logic           kind;
      rsp_fields_type f;
   } deframe_beat_type;

   class deframer_scoreboard;
      deframe_beat_type expected_beats[$];
      int               errors;
      int               max_payload;
      int               max_frame;
      logic [9:0]       byte_pos;
      logic [7:0]       hdr0;
      logic [7:0]       seq;
      logic [15:0]      len_field;
      logic [31:0]      stamp;
      logic [31:0]      rx_crc;
      logic [31:0]      run_crc;
      bit               hdr_ok;

      function new(int mp, int mf);
         max_payload = mp;
         max_frame = mf;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_pos = '0;
         hdr0 = '0;
         seq = '0;
         len_field = '0;
         stamp = '0;
         rx_crc = '0;
         run_crc = CRC_INIT;
         hdr_ok = 1'b0;
      endfunction

      static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] d);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void note_byte(logic [7:0] b, logic eof);
         int               pos;
         int               flen;
         logic [1:0]       ty;
         logic [2:0]       st;
         bit               fwd;
         deframe_beat_type e;
         pos = int'(byte_pos);
         ty = hdr0[7:6];
         fwd = 1'b0;
         if (pos < 8) run_crc = crc_update(run_crc, b);
         if (pos == 0) begin
            hdr0 = b;
            ty = b[7:6];
         end else if (pos == 1) begin
            seq = b;
         end else if (pos < 4) begin
            len_field = {len_field[7:0], b};
         end else if (pos < 8) begin
            stamp = {stamp[23:0], b};
         end else if (pos < HDR_BYTES) begin
            rx_crc = {rx_crc[23:0], b};
            if (pos == HDR_BYTES - 1) begin
               hdr_ok = (ty != TYPE_NONE) && (len_field <= max_payload)
                        && ((run_crc ^ CRC_INIT) == rx_crc);
               run_crc = CRC_INIT;
            end
         end else if (hdr_ok && ty == TYPE_DATA) begin
            if (pos < HDR_BYTES + len_field) begin
               run_crc = crc_update(run_crc, b);
               fwd = 1'b1;
            end else if (pos < HDR_BYTES + len_field + CRC_BYTES) begin
               rx_crc = {rx_crc[23:0], b};
            end
         end
         if (byte_pos != CNT_MAX) byte_pos = byte_pos + 10'd1;

         e.kind = KIND_PAYLOAD;
         e.f = '0;
         if (eof) begin
            flen = pos + 1;
            if (flen < HDR_BYTES) st = ST_NO_HEADER;
            else if (flen > max_frame) st = ST_TOO_LONG;
            else if (ty == TYPE_NONE) st = ST_BAD_TYPE;
            else if (len_field > max_payload) st = ST_BAD_LENGTH;
            else if (!hdr_ok) st = ST_HEADER_CRC;
            else if (ty == TYPE_DATA && flen < HDR_BYTES + len_field + CRC_BYTES)
               st = ST_SHORT;
            else if (ty == TYPE_DATA && (run_crc ^ CRC_INIT) != rx_crc) st = ST_PAYLOAD_CRC;
            else st = ST_OK;
            e.kind = KIND_VERDICT;
            e.f.status = st;
            if (st != ST_NO_HEADER) begin
               e.f.pkt_type = ty;
               e.f.truncated = hdr0[5];
               e.f.window = hdr0[4:0];
               e.f.seq_number = seq;
               e.f.payload_length = len_field;
               e.f.timestamp = stamp;
            end
            expected_beats.push_back(e);
            clear_frame();
         end else if (fwd) begin
            e.f.payload_byte = b;
            expected_beats.push_back(e);
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check_beat(logic kind, logic [RSP_DATA_BITS-1:0] data);
         deframe_beat_type e;
         rsp_fields_type   got;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d, data 0x%0h", kind, data);
            errors++;
            return;
         end
         e = expected_beats.pop_front();
         got = data[RSP_BITS-1:0];
         compare_field("kind", 32'(e.kind), 32'(kind));
         compare_field("payload_byte", 32'(e.f.payload_byte), 32'(got.payload_byte));
         compare_field("status", 32'(e.f.status), 32'(got.status));
         compare_field("pkt_type", 32'(e.f.pkt_type), 32'(got.pkt_type));
         compare_field("truncated", 32'(e.f.truncated), 32'(got.truncated));
         compare_field("window", 32'(e.f.window), 32'(got.window));
         compare_field("seq_number", 32'(e.f.seq_number), 32'(got.seq_number));
         compare_field("payload_length", 32'(e.f.payload_length),
                       32'(got.payload_length));
         compare_field("timestamp", e.f.timestamp, got.timestamp);
      endfunction
   endclass

   localparam int MAX_PAYLOAD = 512;
   localparam int MAX_FRAME = 528;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 75;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [1:0] TYPE_ACK = 2'd2;
   localparam logic [1:0] TYPE_NACK = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   int                       send_idle_pct = 31;
   int                       recv_idle_pct = 47;
   int                       phase = 0;
   int                       bytes_sent = 0;
   int                       cycles = 0;
   int                       hold_left = 0;
   bit                       hold_done = 1'b0;
   logic [7:0]               frame_q[$];
   deframer_scoreboard       sb;

   crc32_packet_deframer #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .MAX_FRAME(MAX_FRAME)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The result side holds off once for a long stretch when the last phase starts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (phase == 2 && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tuser, rsp_tdata);
   end

   function automatic void push_be32(logic [31:0] w);
      frame_q.push_back(w[31:24]);
      frame_q.push_back(w[23:16]);
      frame_q.push_back(w[15:8]);
      frame_q.push_back(w[7:0]);
   endfunction

   function automatic void add_noise(int n);
      logic [7:0] nb;
      for (int i = 0; i < n; i++) begin
         nb = 8'($urandom);
         frame_q.push_back(nb);
      end
   endfunction

   function automatic void cut_to(int n);
      frame_q = frame_q[0:n-1];
   endfunction

   // Builds a frame with correct CRCs unless a bad one is asked for.
   // DATA frames carry pay_cnt payload bytes and a payload CRC.
   function automatic void build_frame(logic [7:0] h0, logic [7:0] sq, logic [15:0] plen,
                                       logic [31:0] ts, int pay_cnt, bit bad_hcrc,
                                       bit bad_pcrc);
      logic [31:0] c;
      logic [7:0]  pb;
      frame_q.delete();
      frame_q.push_back(h0);
      frame_q.push_back(sq);
      frame_q.push_back(plen[15:8]);
      frame_q.push_back(plen[7:0]);
      push_be32(ts);
      c = CRC_INIT;
      for (int i = 0; i < 8; i++) c = crc32_byte(c, frame_q[i]);
      c = ~c;
      if (bad_hcrc) c = c ^ (32'd1 << $urandom_range(31, 0));
      push_be32(c);
      if (h0[7:6] == TYPE_DATA) begin
         c = CRC_INIT;
         for (int i = 0; i < pay_cnt; i++) begin
            pb = 8'($urandom);
            frame_q.push_back(pb);
            c = crc32_byte(c, pb);
         end
         c = ~c;
         if (bad_pcrc) c = c ^ (32'd1 << $urandom_range(31, 0));
         push_be32(c);
      end
   endfunction

   task automatic send_byte(input logic [7:0] d, input logic eof);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(d, eof);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int small_len();
      if ($urandom_range(49, 0) == 0) return $urandom_range(MAX_PAYLOAD, 25);
      return $urandom_range(24, 0);
   endfunction

   task automatic random_frame();
      int         r;
      int         plen;
      logic [7:0] h0;
      r = $urandom_range(99, 0);
      h0 = 8'($urandom);
      if (r < 55) begin
         h0[7:6] = TYPE_DATA;
         plen = small_len();
         build_frame(h0, 8'($urandom), 16'(plen), $urandom, plen, 1'b0, 1'b0);
         if ($urandom_range(9, 0) == 0) add_noise($urandom_range(4, 1));
      end else if (r < 65) begin
         h0[7:6] = $urandom_range(1, 0) ? TYPE_ACK : TYPE_NACK;
         build_frame(h0, 8'($urandom), 16'($urandom_range(MAX_PAYLOAD, 0)), $urandom, 0,
                     1'b0, 1'b0);
         if ($urandom_range(3, 0) == 0) add_noise($urandom_range(4, 1));
      end else if (r < 73) begin
         h0[7:6] = TYPE_DATA;
         plen = $urandom_range(24, 0);
         build_frame(h0, 8'($urandom), 16'(plen), $urandom, plen, 1'b0, 1'b1);
      end else if (r < 80) begin
         h0[7:6] = 2'($urandom_range(3, 1));
         plen = $urandom_range(24, 0);
         build_frame(h0, 8'($urandom), 16'(plen), $urandom, plen, 1'b1, 1'b0);
      end else if (r < 87) begin
         h0[7:6] = TYPE_DATA;
         plen = $urandom_range(24, 0);
         build_frame(h0, 8'($urandom), 16'(plen), $urandom, plen, 1'b0, 1'b0);
         cut_to($urandom_range(frame_q.size() - 1, 1));
      end else if (r < 92) begin
         h0[7:6] = TYPE_NONE;
         build_frame(h0, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0, 1'b0);
         add_noise($urandom_range(8, 0));
      end else if (r < 97) begin
         h0[7:6] = 2'($urandom_range(3, 1));
         build_frame(h0, 8'($urandom), 16'($urandom_range(65535, MAX_PAYLOAD + 1)),
                     $urandom, $urandom_range(8, 0), 1'b0, 1'b0);
      end else begin
         frame_q.delete();
         add_noise($urandom_range(40, 1));
      end
      send_frame();
   endtask

   task automatic run_phase(int p, int s_pct, int r_pct);
      int start;
      phase = p;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_frame();
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      logic [7:0] h0;
      sb = new(MAX_PAYLOAD, MAX_FRAME);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      frame_q.delete();
      frame_q.push_back(8'hFF);
      send_frame();

      build_frame({TYPE_ACK, 6'h3F}, 8'hFF, 16'(MAX_PAYLOAD), 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
      send_frame();

      build_frame({TYPE_NACK, 6'h00}, 8'h00, 16'h0000, 32'h0000_0000, 0, 1'b0, 1'b0);
      cut_to(11);
      send_frame();

      build_frame({TYPE_NACK, 6'h15}, 8'($urandom), 16'd7, $urandom, 0, 1'b0, 1'b0);
      add_noise(3);
      send_frame();

      build_frame({TYPE_NONE, 6'h2A}, 8'($urandom), 16'd5, $urandom, 0, 1'b0, 1'b0);
      send_frame();

      h0 = 8'($urandom);
      h0[7:6] = TYPE_DATA;
      build_frame(h0, 8'($urandom), 16'hFFFF, $urandom, 2, 1'b0, 1'b0);
      send_frame();

      build_frame(h0, 8'($urandom), 16'd2, $urandom, 2, 1'b1, 1'b0);
      send_frame();

      build_frame(h0, 8'($urandom), 16'd0, $urandom, 0, 1'b0, 1'b0);
      send_frame();

      // The flagged byte lands inside the payload, so it yields the verdict, not a payload beat.
      build_frame(h0, 8'($urandom), 16'd3, $urandom, 3, 1'b0, 1'b0);
      cut_to(15);
      send_frame();

      build_frame(h0, 8'($urandom), 16'd4, $urandom, 4, 1'b0, 1'b1);
      send_frame();

      // A full-size payload is forwarded before one extra byte makes the frame too long.
      build_frame(h0, 8'($urandom), 16'(MAX_PAYLOAD), $urandom, MAX_PAYLOAD, 1'b0, 1'b0);
      add_noise(1);
      send_frame();

      run_phase(0, 31, 47);
      run_phase(1, 47, 31);
      run_phase(2, 0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
